// ----- sv/rtlock_pkg.sv -----
package rtlock_pkg;

	// Field widths of the request, result and timeout register
	localparam int REQ_W     = 2;
	localparam int CPU_W     = 3;
	localparam int STATUS_W  = 4;
	localparam int WAIT_W    = 16;
	localparam int DEPTH_W   = 8;
	localparam int TIMEOUT_W = 16;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_LOCK   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TRY    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_UNLOCK = 2'd2;
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_GRANTED     = 4'd0;
	localparam logic [STATUS_W-1:0] ST_NESTED      = 4'd1;
	localparam logic [STATUS_W-1:0] ST_QUEUED      = 4'd2;
	localparam logic [STATUS_W-1:0] ST_TRY_FAILED  = 4'd3;
	localparam logic [STATUS_W-1:0] ST_RELEASED    = 4'd4;
	localparam logic [STATUS_W-1:0] ST_NEST_LOWER  = 4'd5;
	localparam logic [STATUS_W-1:0] ST_NOT_OWNER   = 4'd6;
	localparam logic [STATUS_W-1:0] ST_ALREADY_WT  = 4'd7;
	localparam logic [STATUS_W-1:0] ST_NEST_OVF    = 4'd8;
	localparam logic [STATUS_W-1:0] ST_TICK_DONE   = 4'd9;
	localparam logic [STATUS_W-1:0] ST_DEADLOCK    = 4'd10;

	// Timeout after reset and saturation point of the wait counters
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [WAIT_W-1:0]    WAIT_MAX      = 16'hFFFF;

endpackage

// ----- sv/recursive_ticket_lock.sv -----
// Recursive ticket lock shared by several CPUs.
//
// Input channel (in_valid / in_stall): one transaction is one request, a lock,
// trylock or unlock from the CPU on cpu, or a time tick. A transaction is taken
// when in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall): one or two result transactions per
// request. A release that hands the lock to a waiter gives the release result
// (last low) and then the grant (last high); every other request gives one.
// Timeout register: write cfg_wdata with cfg_we high while the block is idle.
//
// Sequencing: one request is worked on at a time. Lock, trylock and a nested
// or refused unlock pass from acceptance through the EXEC and EMIT1 states
// to the output register. A final unlock and a tick sweep the per-CPU waiter
// entries through one shared compare and increment unit, one entry per cycle,
// in the SCAN state; there are as many waiter entries as CPUs the cpu field
// reaches (8 by default). A second result is loaded from the EMIT2 state.
// A stalled receiver holds the result register and, in turn, the sequencer.
// Reset frees the lock, clears all waiters and the deadlock flag, sets the
// serving ticket to one and the timeout to 1000 ticks.
module recursive_ticket_lock #(
	parameter int NUM_CPUS    = 8,
	parameter int TICKET_BITS = 16,
	parameter int NEST_BITS   = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rtlock_pkg::TIMEOUT_W-1:0]    cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rtlock_pkg::REQ_W-1:0]        req_type,
	input  logic [rtlock_pkg::CPU_W-1:0]        cpu,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rtlock_pkg::CPU_W-1:0]        target_cpu,
	output logic [rtlock_pkg::STATUS_W-1:0]     status,
	output logic [rtlock_pkg::WAIT_W-1:0]       wait_ticks,
	output logic [rtlock_pkg::DEPTH_W-1:0]      nest_depth,
	output logic                                locked,
	output logic                                last
);

	// Only CPUs reachable through the cpu field get a waiter entry
	localparam int CPU_SPAN  = 1 << rtlock_pkg::CPU_W;
	localparam int NSLOTS    = (NUM_CPUS < CPU_SPAN) ? NUM_CPUS : CPU_SPAN;
	localparam int IDX_W     = $clog2(NSLOTS);
	localparam int RED_W     = $clog2(NUM_CPUS + CPU_SPAN);
	localparam int RED_STEPS = (CPU_SPAN - 1) / 2;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NSLOTS - 1);
	localparam logic [NEST_BITS-1:0] NEST_MAX = '1;

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_EMIT1 = 3'd3;
	localparam logic [2:0] S_EMIT2 = 3'd4;

	logic [2:0]                          state_q;
	logic [rtlock_pkg::REQ_W-1:0]        req_q;
	logic [IDX_W-1:0]                    cpu_q;
	logic [rtlock_pkg::TIMEOUT_W-1:0]    timeout_q;
	logic [TICKET_BITS-1:0]              last_tk_q;
	logic [TICKET_BITS-1:0]              serve_q;
	logic                                own_v_q;
	logic [IDX_W-1:0]                    own_q;
	logic [NEST_BITS-1:0]                nest_q;
	logic [NSLOTS-1:0]                   wait_flag_q;
	logic [TICKET_BITS-1:0]              held_q [NSLOTS];
	logic [rtlock_pkg::WAIT_W-1:0]       cnt_q [NSLOTS];
	logic                                dead_q;
	logic [IDX_W-1:0]                    scan_q;
	logic                                two_q;
	logic                                found_q;
	logic [IDX_W-1:0]                    r1_cpu_q;
	logic [rtlock_pkg::STATUS_W-1:0]     r1_status_q;
	logic [rtlock_pkg::WAIT_W-1:0]       r1_wait_q;
	logic [IDX_W-1:0]                    r2_cpu_q;
	logic [rtlock_pkg::WAIT_W-1:0]       r2_wait_q;

	logic                                out_valid_q;
	logic [rtlock_pkg::CPU_W-1:0]        out_cpu_q;
	logic [rtlock_pkg::STATUS_W-1:0]     out_status_q;
	logic [rtlock_pkg::WAIT_W-1:0]       out_wait_q;
	logic [rtlock_pkg::DEPTH_W-1:0]      out_depth_q;
	logic                                out_locked_q;
	logic                                out_last_q;

	logic [RED_W-1:0]                    cpu_red;
	logic                                is_owner;
	logic [TICKET_BITS-1:0]              tk_next;
	logic                                grant_now;
	logic                                enq;
	logic                                hit;
	logic [rtlock_pkg::WAIT_W-1:0]       cnt_cur;
	logic [rtlock_pkg::WAIT_W-1:0]       cnt_inc;
	logic                                out_free;
	logic [rtlock_pkg::STATUS_W-1:0]     r1_status_fin;
	logic [IDX_W+rtlock_pkg::CPU_W-1:0]  r1_cpu_ext;
	logic [IDX_W+rtlock_pkg::CPU_W-1:0]  r2_cpu_ext;
	logic [NEST_BITS+rtlock_pkg::DEPTH_W-1:0] nest_ext;

	// Fold the requesting CPU into the range of CPUs by repeated subtraction
	always_comb begin
		cpu_red = RED_W'(cpu);
		for (int k = 0; k < RED_STEPS; k++) begin
			if (cpu_red >= RED_W'(NUM_CPUS)) begin
				cpu_red = cpu_red - RED_W'(NUM_CPUS);
			end
		end
	end

	assign is_owner  = own_v_q && (own_q == cpu_q);
	assign tk_next   = last_tk_q + TICKET_BITS'(1);
	assign grant_now = !own_v_q && (tk_next == serve_q);
	// Queue a plain lock from a CPU that neither owns nor waits, when not granted
	assign enq = (state_q == S_EXEC) && (req_q == rtlock_pkg::REQ_LOCK) && !is_owner
		&& !wait_flag_q[cpu_q] && !grant_now;

	// Shared scan unit: one waiter entry per cycle
	assign cnt_cur = cnt_q[scan_q];
	assign cnt_inc = (cnt_cur == rtlock_pkg::WAIT_MAX) ? cnt_cur
		: cnt_cur + rtlock_pkg::WAIT_W'(1);
	assign hit = wait_flag_q[scan_q] && (held_q[scan_q] == serve_q);

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		r1_cpu_ext = {{rtlock_pkg::CPU_W{1'b0}}, r1_cpu_q};
		r2_cpu_ext = {{rtlock_pkg::CPU_W{1'b0}}, r2_cpu_q};
		nest_ext   = {{rtlock_pkg::DEPTH_W{1'b0}}, nest_q};
		if (req_q == rtlock_pkg::REQ_TICK) begin
			r1_status_fin = dead_q ? rtlock_pkg::ST_DEADLOCK : rtlock_pkg::ST_TICK_DONE;
		end else begin
			r1_status_fin = r1_status_q;
		end
	end

	// Ticket of each waiter; read only while its waiting flag is set
	always_ff @(posedge clk) begin
		if (enq) begin
			held_q[cpu_q] <= tk_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= rtlock_pkg::REQ_LOCK;
			cpu_q        <= '0;
			timeout_q    <= rtlock_pkg::TIMEOUT_RESET;
			last_tk_q    <= '0;
			serve_q      <= TICKET_BITS'(1);
			own_v_q      <= 1'b0;
			own_q        <= '0;
			nest_q       <= '0;
			wait_flag_q  <= '0;
			for (int i = 0; i < NSLOTS; i++) begin
				cnt_q[i] <= '0;
			end
			dead_q       <= 1'b0;
			scan_q       <= '0;
			two_q        <= 1'b0;
			found_q      <= 1'b0;
			r1_cpu_q     <= '0;
			r1_status_q  <= rtlock_pkg::ST_GRANTED;
			r1_wait_q    <= '0;
			r2_cpu_q     <= '0;
			r2_wait_q    <= '0;
			out_valid_q  <= 1'b0;
			out_cpu_q    <= '0;
			out_status_q <= rtlock_pkg::ST_GRANTED;
			out_wait_q   <= '0;
			out_depth_q  <= '0;
			out_locked_q <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			// Drop a taken result unless an emit state loads the next one
			if (out_valid_q && !out_stall && (state_q != S_EMIT1) && (state_q != S_EMIT2)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= req_type;
						cpu_q   <= cpu_red[IDX_W-1:0];
						state_q <= S_EXEC;
					end
				end

				S_EXEC: begin
					two_q     <= 1'b0;
					found_q   <= 1'b0;
					scan_q    <= '0;
					r1_wait_q <= '0;
					r1_cpu_q  <= (req_q == rtlock_pkg::REQ_TICK) ? '0 : cpu_q;
					unique case (req_q)
						rtlock_pkg::REQ_LOCK, rtlock_pkg::REQ_TRY: begin
							state_q <= S_EMIT1;
							if (is_owner) begin
								if (nest_q == NEST_MAX) begin
									r1_status_q <= rtlock_pkg::ST_NEST_OVF;
								end else begin
									nest_q      <= nest_q + NEST_BITS'(1);
									r1_status_q <= rtlock_pkg::ST_NESTED;
								end
							end else if (wait_flag_q[cpu_q]) begin
								r1_status_q <= rtlock_pkg::ST_ALREADY_WT;
							end else if (grant_now) begin
								last_tk_q   <= tk_next;
								own_v_q     <= 1'b1;
								own_q       <= cpu_q;
								nest_q      <= NEST_BITS'(1);
								r1_status_q <= rtlock_pkg::ST_GRANTED;
							end else if (req_q == rtlock_pkg::REQ_TRY) begin
								r1_status_q <= rtlock_pkg::ST_TRY_FAILED;
							end else begin
								last_tk_q          <= tk_next;
								wait_flag_q[cpu_q] <= 1'b1;
								cnt_q[cpu_q]       <= '0;
								r1_status_q        <= rtlock_pkg::ST_QUEUED;
							end
						end
						rtlock_pkg::REQ_UNLOCK: begin
							if (!is_owner) begin
								r1_status_q <= rtlock_pkg::ST_NOT_OWNER;
								state_q     <= S_EMIT1;
							end else if (nest_q > NEST_BITS'(1)) begin
								nest_q      <= nest_q - NEST_BITS'(1);
								r1_status_q <= rtlock_pkg::ST_NEST_LOWER;
								state_q     <= S_EMIT1;
							end else begin
								// Free the lock, advance serving and look for its holder
								own_v_q     <= 1'b0;
								own_q       <= '0;
								nest_q      <= '0;
								serve_q     <= serve_q + TICKET_BITS'(1);
								r1_status_q <= rtlock_pkg::ST_RELEASED;
								state_q     <= S_SCAN;
							end
						end
						rtlock_pkg::REQ_TICK: begin
							r1_status_q <= rtlock_pkg::ST_TICK_DONE;
							state_q     <= S_SCAN;
						end
					endcase
				end

				S_SCAN: begin
					if (req_q == rtlock_pkg::REQ_UNLOCK) begin
						if (hit) begin
							// Hand the lock over to the matching waiter
							wait_flag_q[scan_q] <= 1'b0;
							cnt_q[scan_q]       <= '0;
							own_v_q             <= 1'b1;
							own_q               <= scan_q;
							nest_q              <= NEST_BITS'(1);
							r2_cpu_q            <= scan_q;
							r2_wait_q           <= cnt_cur;
							two_q               <= 1'b1;
							state_q             <= S_EMIT1;
						end else if (scan_q == LAST_IDX) begin
							state_q <= S_EMIT1;
						end else begin
							scan_q <= scan_q + IDX_W'(1);
						end
					end else begin
						// Age a waiter and flag it once past the timeout
						if (wait_flag_q[scan_q]) begin
							cnt_q[scan_q] <= cnt_inc;
							if (cnt_inc > timeout_q) begin
								dead_q <= 1'b1;
								if (!found_q) begin
									found_q   <= 1'b1;
									r1_cpu_q  <= scan_q;
									r1_wait_q <= cnt_inc;
								end
							end
						end
						if (scan_q == LAST_IDX) begin
							state_q <= S_EMIT1;
						end else begin
							scan_q <= scan_q + IDX_W'(1);
						end
					end
				end

				S_EMIT1: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_cpu_q    <= r1_cpu_ext[rtlock_pkg::CPU_W-1:0];
						out_status_q <= r1_status_fin;
						out_wait_q   <= r1_wait_q;
						out_depth_q  <= nest_ext[rtlock_pkg::DEPTH_W-1:0];
						out_locked_q <= own_v_q;
						out_last_q   <= !two_q;
						state_q      <= two_q ? S_EMIT2 : S_IDLE;
					end
				end

				S_EMIT2: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_cpu_q    <= r2_cpu_ext[rtlock_pkg::CPU_W-1:0];
						out_status_q <= rtlock_pkg::ST_GRANTED;
						out_wait_q   <= r2_wait_q;
						out_depth_q  <= nest_ext[rtlock_pkg::DEPTH_W-1:0];
						out_locked_q <= own_v_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign target_cpu = out_cpu_q;
	assign status     = out_status_q;
	assign wait_ticks = out_wait_q;
	assign nest_depth = out_depth_q;
	assign locked     = out_locked_q;
	assign last       = out_last_q;

	// The lock is held exactly when the nest count is nonzero
	a_owner_nest: assert property (@(posedge clk) disable iff (!arst_n)
		own_v_q == (nest_q != '0))
		else $error("owner flag and nest count disagree");

	// The owner never sits in the waiter queue
	a_owner_not_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		own_v_q |-> !wait_flag_q[own_q])
		else $error("owning CPU is also marked waiting");

	// Only a release with handover is followed by a second result, a grant
	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (status == rtlock_pkg::ST_RELEASED) && locked)
		else $error("non-final result is not a release with handover");

endmodule

// ----- bench/tb_top.sv -----
module tb_top;

	// One request as it travels on the input channel
	typedef struct packed {
		logic [rtlock_pkg::REQ_W-1:0] req;
		logic [rtlock_pkg::CPU_W-1:0] cpu;
	} lock_req_t;

	// One result transaction as the block should present it
	typedef struct packed {
		logic [rtlock_pkg::CPU_W-1:0]    cpu;
		logic [rtlock_pkg::STATUS_W-1:0] status;
		logic [rtlock_pkg::WAIT_W-1:0]   ticks;
		logic [rtlock_pkg::DEPTH_W-1:0]  depth;
		logic                            locked;
		logic                            last;
	} lock_result_t;

	// Shadow of everything the lock remembers, plus the timeout register
	typedef struct packed {
		logic [rtlock_pkg::TIMEOUT_W-1:0]     timeout;
		logic [15:0]                          issued;
		logic [15:0]                          serving;
		logic                                 owned;
		logic [rtlock_pkg::CPU_W-1:0]         owner;
		logic [rtlock_pkg::DEPTH_W-1:0]       depth;
		logic [7:0]                           waiting;
		logic [7:0][15:0]                     ticket;
		logic [7:0][rtlock_pkg::WAIT_W-1:0]   waited;
		logic                                 deadlock;
	} lock_state_t;

	// Longest run of cycles with no transaction on either channel. The worst
	// correct gap is the long receiver hold-off (HOLD_CYCLES) plus a slow
	// unlock sweep; several times that is allowed before giving up.
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_we = 1'b0;
	logic [rtlock_pkg::TIMEOUT_W-1:0]     cfg_wdata = '0;
	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	logic [rtlock_pkg::REQ_W-1:0]         req_type = '0;
	logic [rtlock_pkg::CPU_W-1:0]         cpu = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic [rtlock_pkg::CPU_W-1:0]         target_cpu;
	logic [rtlock_pkg::STATUS_W-1:0]      status;
	logic [rtlock_pkg::WAIT_W-1:0]        wait_ticks;
	logic [rtlock_pkg::DEPTH_W-1:0]       nest_depth;
	logic                                 locked;
	logic                                 last;

	lock_req_t    pending_reqs[$];   // requests waiting to be offered
	lock_result_t due_results[$];    // results owed by the block, oldest first
	lock_state_t  lock_now;          // lock as seen through accepted requests
	lock_state_t  lock_planned;      // lock as it will be after all queued requests

	int errors = 0;
	int send_idle = 0;               // percent of cycles the sender holds back
	int recv_idle = 0;               // percent of cycles the receiver stalls
	int quiet = 0;
	int hold_left = 0;
	logic press_arm = 1'b0;
	logic press_done = 1'b0;

	recursive_ticket_lock uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.cpu        (cpu),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.target_cpu (target_cpu),
		.status     (status),
		.wait_ticks (wait_ticks),
		.nest_depth (nest_depth),
		.locked     (locked),
		.last       (last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic lock_state_t lock_reset_state();
		lock_state_t s;
		s = '0;
		s.timeout = rtlock_pkg::TIMEOUT_RESET;
		s.serving = 16'd1;
		return s;
	endfunction

	// Advance the shadow lock by one request and give the one or two results it
	// causes. Both results carry the nest count and lock flag after the whole
	// step, so a release that hands over already shows the new owner's depth.
	function automatic void lock_step(inout lock_state_t s,
			input logic [rtlock_pkg::REQ_W-1:0] rq,
			input logic [rtlock_pkg::CPU_W-1:0] c, output lock_result_t r0,
			output lock_result_t r1, output int n);
		logic is_owner;
		logic found;
		logic [15:0] next_ticket;
		is_owner = s.owned && s.owner == c;
		found = 1'b0;
		r0 = '0;
		r1 = '0;
		n = 1;
		r0.cpu = c;
		case (rq)
			rtlock_pkg::REQ_LOCK, rtlock_pkg::REQ_TRY: begin
				if (is_owner) begin
					// Owner re-acquires: deepen, or refuse at the top of the count
					if (s.depth == {rtlock_pkg::DEPTH_W{1'b1}}) begin
						r0.status = rtlock_pkg::ST_NEST_OVF;
					end else begin
						s.depth = s.depth + 1'b1;
						r0.status = rtlock_pkg::ST_NESTED;
					end
				end else if (s.waiting[c]) begin
					r0.status = rtlock_pkg::ST_ALREADY_WT;
				end else begin
					next_ticket = s.issued + 1'b1;
					if (!s.owned && next_ticket == s.serving) begin
						s.issued = next_ticket;
						s.owned = 1'b1;
						s.owner = c;
						s.depth = rtlock_pkg::DEPTH_W'(1);
						r0.status = rtlock_pkg::ST_GRANTED;
					end else if (rq == rtlock_pkg::REQ_TRY) begin
						// Busy lock: trylock draws no ticket
						r0.status = rtlock_pkg::ST_TRY_FAILED;
					end else begin
						s.issued = next_ticket;
						s.waiting[c] = 1'b1;
						s.ticket[c] = next_ticket;
						s.waited[c] = '0;
						r0.status = rtlock_pkg::ST_QUEUED;
					end
				end
			end
			rtlock_pkg::REQ_UNLOCK: begin
				if (!is_owner) begin
					r0.status = rtlock_pkg::ST_NOT_OWNER;
				end else if (s.depth > 1) begin
					s.depth = s.depth - 1'b1;
					r0.status = rtlock_pkg::ST_NEST_LOWER;
				end else begin
					s.owned = 1'b0;
					s.owner = '0;
					s.depth = '0;
					s.serving = s.serving + 1'b1;
					r0.status = rtlock_pkg::ST_RELEASED;
					// Hand over to the waiter holding the new serving ticket
					for (int i = 0; i < 8; i++) begin
						if (!found && s.waiting[i] && s.ticket[i] == s.serving) begin
							found = 1'b1;
							r1.cpu = rtlock_pkg::CPU_W'(i);
							r1.status = rtlock_pkg::ST_GRANTED;
							r1.ticks = s.waited[i];
							s.waiting[i] = 1'b0;
							s.waited[i] = '0;
							s.owned = 1'b1;
							s.owner = rtlock_pkg::CPU_W'(i);
							s.depth = rtlock_pkg::DEPTH_W'(1);
							n = 2;
						end
					end
				end
			end
			default: begin
				// Tick: age every waiter, report the lowest one past the timeout
				r0.cpu = '0;
				for (int i = 0; i < 8; i++) begin
					if (s.waiting[i]) begin
						if (s.waited[i] != rtlock_pkg::WAIT_MAX)
							s.waited[i] = s.waited[i] + 1'b1;
						if (s.waited[i] > s.timeout) begin
							s.deadlock = 1'b1;
							if (!found) begin
								found = 1'b1;
								r0.cpu = rtlock_pkg::CPU_W'(i);
								r0.ticks = s.waited[i];
							end
						end
					end
				end
				r0.status = s.deadlock ? rtlock_pkg::ST_DEADLOCK : rtlock_pkg::ST_TICK_DONE;
			end
		endcase
		r0.depth = s.depth;
		r0.locked = s.owned;
		r1.depth = s.depth;
		r1.locked = s.owned;
		r0.last = (n == 1);
		r1.last = 1'b1;
	endfunction

	task automatic report(input string msg);
		errors++;
		if (errors <= 40)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic compare(input string field, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report($sformatf("%s got %0d, want %0d", field, got, want));
	endtask

	// Queue a request and advance the planned lock so later choices can
	// target the owner that will exist by then
	task automatic queue_req(input logic [rtlock_pkg::REQ_W-1:0] rq,
			input logic [rtlock_pkg::CPU_W-1:0] c);
		lock_result_t a;
		lock_result_t b;
		lock_req_t item;
		int n;
		lock_step(lock_planned, rq, c, a, b, n);
		item.req = rq;
		item.cpu = c;
		pending_reqs.push_back(item);
	endtask

	// Mostly well-formed traffic: unlocks go to the owner, locks from random
	// CPUs nest, queue or bounce; a share of unlocks from anyone and ticks
	task automatic random_mix(input int count);
		int pick;
		logic [rtlock_pkg::CPU_W-1:0] c;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			c = rtlock_pkg::CPU_W'($urandom_range(7));
			if (pick < 28)
				queue_req(rtlock_pkg::REQ_LOCK, c);
			else if (pick < 38)
				queue_req(rtlock_pkg::REQ_TRY, c);
			else if (pick < 68)
				queue_req(rtlock_pkg::REQ_UNLOCK, lock_planned.owned ? lock_planned.owner : c);
			else if (pick < 76)
				queue_req(rtlock_pkg::REQ_UNLOCK, c);
			else
				queue_req(rtlock_pkg::REQ_TICK, c);
		end
	endtask

	// Wait until every request is taken and every result has come back,
	// then give the block time to show anything extra
	task automatic settle();
		while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_timeout(input logic [rtlock_pkg::TIMEOUT_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		lock_planned.timeout = v;
		@(negedge clk);
	endtask

	// Driver: offer the next request unless the current one is stalled; while
	// idle, scramble the payload so the block must ignore it
	always @(posedge clk) begin : drive_requests
		lock_req_t item;
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
					item = pending_reqs.pop_front();
					in_valid <= 1'b1;
					req_type <= item.req;
					cpu <= item.cpu;
				end else begin
					in_valid <= 1'b0;
					req_type <= rtlock_pkg::REQ_W'($urandom_range(3));
					cpu <= rtlock_pkg::CPU_W'($urandom_range(7));
				end
			end
		end
	end

	// Receiver: random stalls, or one long hold-off once armed so the result
	// register stays full and the input backs up
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (press_arm && !press_done) begin
				out_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				press_done <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	// Monitor: check each accepted result against the oldest owed one, then
	// predict for a request taken at this edge. Mirror register writes.
	always @(posedge clk) begin : observe
		lock_result_t r0;
		lock_result_t r1;
		lock_result_t want;
		int n;
		if (arst_n) begin
			if (cfg_we)
				lock_now.timeout = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					report($sformatf("unexpected result cpu %0d status %0d", target_cpu, status));
				end else begin
					want = due_results.pop_front();
					compare("target_cpu", 16'(target_cpu), 16'(want.cpu));
					compare("status", 16'(status), 16'(want.status));
					compare("wait_ticks", wait_ticks, want.ticks);
					compare("nest_depth", 16'(nest_depth), 16'(want.depth));
					compare("locked", 16'(locked), 16'(want.locked));
					compare("last", 16'(last), 16'(want.last));
				end
			end
			if (in_valid && !in_stall) begin
				lock_step(lock_now, req_type, cpu, r0, r1, n);
				due_results.push_back(r0);
				if (n == 2)
					due_results.push_back(r1);
			end
		end
	end

	// Watchdog: give up when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
				if (quiet >= QUIET_LIMIT) begin
					$display("recursive_ticket_lock verification failed");
					$finish;
				end
			end
		end
	end

	initial begin : sequence_run
		lock_now = lock_reset_state();
		lock_planned = lock_reset_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sender idles a third of the time, receiver most of the time
		send_idle = 34;
		recv_idle = 73;

		// Directed: refused unlock on a free lock, tick with no waiters,
		// trylock grant, nesting through both acquire kinds, trylock on a busy
		// lock, queueing, acquire while queued, unlock by a waiter, aging,
		// nest lowering, handover on release twice, plain release
		queue_req(rtlock_pkg::REQ_UNLOCK, 3'd0);
		queue_req(rtlock_pkg::REQ_TICK, 3'd7);
		queue_req(rtlock_pkg::REQ_TRY, 3'd7);
		queue_req(rtlock_pkg::REQ_LOCK, 3'd7);
		queue_req(rtlock_pkg::REQ_TRY, 3'd7);
		queue_req(rtlock_pkg::REQ_TRY, 3'd3);
		queue_req(rtlock_pkg::REQ_LOCK, 3'd3);
		queue_req(rtlock_pkg::REQ_LOCK, 3'd3);
		queue_req(rtlock_pkg::REQ_TRY, 3'd3);
		queue_req(rtlock_pkg::REQ_LOCK, 3'd0);
		queue_req(rtlock_pkg::REQ_UNLOCK, 3'd0);
		queue_req(rtlock_pkg::REQ_TICK, 3'd5);
		queue_req(rtlock_pkg::REQ_TICK, 3'd2);
		queue_req(rtlock_pkg::REQ_UNLOCK, 3'd7);
		queue_req(rtlock_pkg::REQ_UNLOCK, 3'd7);
		queue_req(rtlock_pkg::REQ_UNLOCK, 3'd7);
		queue_req(rtlock_pkg::REQ_UNLOCK, 3'd3);
		queue_req(rtlock_pkg::REQ_LOCK, 3'd0);
		queue_req(rtlock_pkg::REQ_UNLOCK, 3'd0);
		queue_req(rtlock_pkg::REQ_UNLOCK, 3'd0);
		queue_req(rtlock_pkg::REQ_LOCK, 3'd4);
		queue_req(rtlock_pkg::REQ_LOCK, 3'd1);
		queue_req(rtlock_pkg::REQ_TICK, 3'd6);
		queue_req(rtlock_pkg::REQ_UNLOCK, 3'd4);
		queue_req(rtlock_pkg::REQ_UNLOCK, 3'd1);
		settle();

		// Largest timeout: waiters never count as deadlocked
		set_timeout({rtlock_pkg::TIMEOUT_W{1'b1}});
		random_mix(130);
		settle();

		// Swap the idling sides; a short timeout raises the sticky flag
		send_idle = 73;
		recv_idle = 34;
		set_timeout(16'd6);
		random_mix(130);
		settle();

		// No idling; timeout of one tick; one long receiver hold-off up front
		send_idle = 0;
		recv_idle = 0;
		set_timeout(16'd1);
		random_mix(140);
		press_arm = 1'b1;
		settle();

		if (errors == 0 && due_results.size() == 0)
			$display("recursive_ticket_lock verification clean");
		else
			$display("recursive_ticket_lock verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
sv/rtlock_pkg.sv
sv/recursive_ticket_lock.sv
bench/tb_top.sv
